// ===== src/assert_macros.svh =====
// Assertion macros shared by the sampled latency statistics unit.
// Each module that asserts includes this file; the checks vanish under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge of clk while rst_n is high.
`define SLSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slsu assertion failed");
// Check that a condition never holds.
`define SLSU_ASSERT_NEVER(lbl, expr) \
  `SLSU_ASSERT(lbl, !(expr))
`else
`define SLSU_ASSERT(lbl, prop)
`define SLSU_ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== src/slsu_pkg.sv =====
// Shared types, widths and codes for the sampled latency statistics unit.
// No dependencies; every module refers to it by scoped names.
`timescale 1ns / 1ps
package slsu_pkg;

  localparam int NUM_METRICS = 9;
  localparam int MET_W       = $clog2(NUM_METRICS);
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 48;
  localparam int DUR_W       = 32;
  localparam int EVERY_W     = 16;
  localparam int DIV_CNT_W   = $clog2(CNT_W + 1);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Request codes on the input port
  localparam logic [1:0] REQ_RECORD = 2'd0;
  localparam logic [1:0] REQ_FRAME  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RATE = 1'd1;

  // Classified operations handed to the back end
  typedef logic [1:0] op_t;
  localparam op_t OP_READ  = 2'd0;  // report only
  localparam op_t OP_REC   = 2'd1;  // count an attempt, maybe keep the duration
  localparam op_t OP_FRAME = 2'd2;  // count a replaced frame
  localparam op_t OP_CLEAR = 2'd3;  // zero every counter

  typedef struct packed {
    op_t              op;
    logic             valid;
    logic [MET_W-1:0] idx;
    logic [DUR_W-1:0] dur;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/sampled_latency_stats_unit.sv =====
// An accepted request makes one or two passes through the shared 48-bit bit-serial
// divider before its result strobe; the second pass runs only for a nonzero sample count.
// The back end takes one request at a time and the divider is the limit,
// and a two-entry queue lets up to three requests wait behind it.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Synchronous active-low reset zeroes all counters, enable=0, keep rate 1.
`timescale 1ns / 1ps
module sampled_latency_stats_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [slsu_pkg::IDX_W-1:0]     in_metric_index,
  input  logic [slsu_pkg::DUR_W-1:0]     in_duration_us,
  // result channel
  output logic                           out_valid,
  output logic [slsu_pkg::CNT_W-1:0]     out_sample_count,
  output logic [slsu_pkg::DUR_W-1:0]     out_mean_us,
  output logic [slsu_pkg::DUR_W-1:0]     out_max_us,
  output logic [slsu_pkg::CNT_W-1:0]     out_replaced_frames,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slsu_pkg::EVERY_W-1:0]   cfg_wdata
);

  logic                         enable_r;
  logic [slsu_pkg::EVERY_W-1:0] every_r;
  logic                         q_push;
  logic                         q_pop;
  slsu_pkg::cmd_t               q_in;
  slsu_pkg::cmd_t               q_out;
  slsu_pkg::q_stat_t            q_stat;

  // Configuration registers are always ready; a keep rate of zero
  // is stored as one so the divider never sees a zero divisor.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      every_r  <= slsu_pkg::EVERY_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slsu_pkg::CFG_ENABLE:    enable_r <= cfg_wdata[0];
        slsu_pkg::CFG_KEEP_RATE: every_r  <= (cfg_wdata == '0) ?
                                             slsu_pkg::EVERY_W'(1) : cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: take and classify requests, hold one while the queue is full
  slsu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (in_req_type),
    .metric_index (in_metric_index),
    .duration_us  (in_duration_us),
    .enable       (enable_r),
    .q_stat       (q_stat),
    .push         (q_push),
    .push_data    (q_in)
  );

  // Decouple intake from the slow divider-bound back end
  slsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // Back end: update counters, derive sample count and mean, strobe result
  slsu_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_data              (q_out),
    .q_pop               (q_pop),
    .every               (every_r),
    .out_valid           (out_valid),
    .out_sample_count    (out_sample_count),
    .out_mean_us         (out_mean_us),
    .out_max_us          (out_max_us),
    .out_replaced_frames (out_replaced_frames)
  );

endmodule

// ===== src/slsu_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on slsu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  slsu_pkg::cmd_t    push_data,
  input  logic              pop,
  output slsu_pkg::cmd_t    pop_data,
  output slsu_pkg::q_stat_t stat
);

  slsu_pkg::cmd_t                    mem_r [slsu_pkg::QDEPTH];
  logic [slsu_pkg::QPTR_W-1:0]       wptr_r;
  logic [slsu_pkg::QPTR_W-1:0]       rptr_r;
  logic [slsu_pkg::QCNT_W-1:0]       cnt_r;

  always_comb begin
    stat.full  = (cnt_r == slsu_pkg::QCNT_W'(slsu_pkg::QDEPTH));
    stat.empty = (cnt_r == '0);
    pop_data   = mem_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  `SLSU_ASSERT_NEVER(a_no_overflow, push && stat.full)
  `SLSU_ASSERT_NEVER(a_no_underflow, pop && stat.empty)
  `SLSU_ASSERT(a_cnt_bound, cnt_r <= slsu_pkg::QCNT_W'(slsu_pkg::QDEPTH))

endmodule

// ===== src/slsu_front.sv =====
// Front end: takes requests, classifies them and feeds the command queue.
// Depends on slsu_pkg.
`timescale 1ns / 1ps
module slsu_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [slsu_pkg::IDX_W-1:0]  metric_index,
  input  logic [slsu_pkg::DUR_W-1:0]  duration_us,
  input  logic                        enable,
  input  slsu_pkg::q_stat_t           q_stat,
  output logic                        push,
  output slsu_pkg::cmd_t              push_data
);

  logic           hold_r;
  logic           hold_nxt;
  slsu_pkg::cmd_t cmd_r;
  slsu_pkg::cmd_t cmd_nxt;
  logic           accept;
  logic           in_range;

  assign push      = hold_r && !q_stat.full;
  assign busy      = hold_r && q_stat.full;
  assign accept    = start && !busy;
  assign push_data = cmd_r;
  assign hold_nxt  = accept || (hold_r && !push);
  assign in_range  = 32'(metric_index) < slsu_pkg::NUM_METRICS;

  // Decide now what the back end must do; disabled records and frames, and
  // out-of-range records, collapse into a plain read.
  always_comb begin
    cmd_nxt.valid = in_range;
    cmd_nxt.idx   = in_range ? metric_index[slsu_pkg::MET_W-1:0] : '0;
    cmd_nxt.dur   = duration_us;
    unique case (req_type)
      slsu_pkg::REQ_RECORD: cmd_nxt.op = (enable && in_range) ? slsu_pkg::OP_REC
                                                              : slsu_pkg::OP_READ;
      slsu_pkg::REQ_FRAME:  cmd_nxt.op = enable ? slsu_pkg::OP_FRAME : slsu_pkg::OP_READ;
      slsu_pkg::REQ_CLEAR:  cmd_nxt.op = slsu_pkg::OP_CLEAR;
      default:              cmd_nxt.op = slsu_pkg::OP_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hold_r <= 1'b0;
    else        hold_r <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) cmd_r <= cmd_nxt;
  end

endmodule

// ===== src/slsu_div.sv =====
// Shared restoring divider, one quotient bit per cycle over the counter width.
// Depends on slsu_pkg.
`timescale 1ns / 1ps
module slsu_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [slsu_pkg::CNT_W-1:0] dividend,
  input  logic [slsu_pkg::CNT_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [slsu_pkg::CNT_W-1:0] quotient,
  output logic [slsu_pkg::CNT_W-1:0] remainder
);

  localparam int W = slsu_pkg::CNT_W;

  logic [W-1:0]                   rem_r;
  logic [W-1:0]                   quo_r;
  logic [W-1:0]                   dvs_r;
  logic [slsu_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [W:0]                     rem_sh;
  logic [W:0]                     diff;
  logic                           take;

  assign busy      = (cnt_r != '0);
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  always_comb begin
    rem_sh = {rem_r, quo_r[W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    take   = !diff[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (cnt_r == slsu_pkg::DIV_CNT_W'(1));
      if (start)     cnt_r <= slsu_pkg::DIV_CNT_W'(W);
      else if (busy) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy) begin
      rem_r <= take ? diff[W-1:0] : rem_sh[W-1:0];
      quo_r <= {quo_r[W-2:0], take};
    end
  end

endmodule

// ===== src/slsu_back.sv =====
// Back end: holds the per-metric counters, runs each command through the
// shared divider and drives the result strobe. Depends on slsu_pkg,
// slsu_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slsu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  slsu_pkg::q_stat_t            q_stat,
  input  slsu_pkg::cmd_t               q_data,
  output logic                         q_pop,
  input  logic [slsu_pkg::EVERY_W-1:0] every,
  output logic                         out_valid,
  output logic [slsu_pkg::CNT_W-1:0]   out_sample_count,
  output logic [slsu_pkg::DUR_W-1:0]   out_mean_us,
  output logic [slsu_pkg::DUR_W-1:0]   out_max_us,
  output logic [slsu_pkg::CNT_W-1:0]   out_replaced_frames
);

  localparam int CW = slsu_pkg::CNT_W;
  localparam int DW = slsu_pkg::DUR_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_SAMP  = 3'd2;
  localparam logic [2:0] ST_WSAMP = 3'd3;
  localparam logic [2:0] ST_MEAN  = 3'd4;
  localparam logic [2:0] ST_WMEAN = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]     state_r;
  logic [2:0]     state_nxt;
  slsu_pkg::cmd_t cmd_r;

  logic [CW-1:0]  att_r  [slsu_pkg::NUM_METRICS];
  logic [CW-1:0]  tot_r  [slsu_pkg::NUM_METRICS];
  logic [DW-1:0]  peak_r [slsu_pkg::NUM_METRICS];
  logic [CW-1:0]  frames_r;

  logic [CW-1:0]  samples_r;
  logic [DW-1:0]  mean_r;
  logic           out_valid_r;
  logic [CW-1:0]  out_samples_r;
  logic [DW-1:0]  out_mean_r;
  logic [DW-1:0]  out_max_r;
  logic [CW-1:0]  out_frames_r;

  logic [CW-1:0]  att_sel;
  logic [CW-1:0]  tot_sel;
  logic [DW-1:0]  peak_sel;

  logic           div_start;
  logic [CW-1:0]  div_dividend;
  logic [CW-1:0]  div_divisor;
  logic           div_busy;
  logic           div_done;
  logic [CW-1:0]  div_quo;
  logic [CW-1:0]  div_rem;
  logic           keep;

  assign att_sel  = cmd_r.valid ? att_r[cmd_r.idx]  : '0;
  assign tot_sel  = cmd_r.valid ? tot_r[cmd_r.idx]  : '0;
  assign peak_sel = cmd_r.valid ? peak_r[cmd_r.idx] : '0;

  assign q_pop        = (state_r == ST_IDLE) && !q_stat.empty;
  assign div_start    = (state_r == ST_SAMP) || (state_r == ST_MEAN);
  assign div_dividend = (state_r == ST_SAMP) ? att_sel : tot_sel;
  assign div_divisor  = (state_r == ST_SAMP) ? CW'(every) : samples_r;
  assign keep         = (cmd_r.op == slsu_pkg::OP_REC) && (div_rem == '0);

  slsu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (!q_stat.empty) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_SAMP;
      ST_SAMP:  state_nxt = ST_WSAMP;
      ST_WSAMP: if (div_done) begin
        state_nxt = (cmd_r.valid && div_quo != '0) ? ST_MEAN : ST_OUT;
      end
      ST_MEAN:  state_nxt = ST_WMEAN;
      ST_WMEAN: if (div_done) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control and counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      frames_r    <= '0;
      for (int i = 0; i < slsu_pkg::NUM_METRICS; i++) begin
        att_r[i]  <= '0;
        tot_r[i]  <= '0;
        peak_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_OUT);
      if (state_r == ST_UPD) begin
        case (cmd_r.op)
          slsu_pkg::OP_REC:   att_r[cmd_r.idx] <= att_r[cmd_r.idx] + 1'b1;
          slsu_pkg::OP_FRAME: frames_r <= frames_r + 1'b1;
          slsu_pkg::OP_CLEAR: begin
            frames_r <= '0;
            for (int i = 0; i < slsu_pkg::NUM_METRICS; i++) begin
              att_r[i]  <= '0;
              tot_r[i]  <= '0;
              peak_r[i] <= '0;
            end
          end
          default: ;
        endcase
      end
      // Keep the duration when the new attempt count is a multiple of every
      if (state_r == ST_WSAMP && div_done && keep) begin
        tot_r[cmd_r.idx] <= tot_r[cmd_r.idx] + CW'(cmd_r.dur);
        if (cmd_r.dur > peak_r[cmd_r.idx]) peak_r[cmd_r.idx] <= cmd_r.dur;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_data;
    if (state_r == ST_WSAMP && div_done) begin
      samples_r <= cmd_r.valid ? div_quo : '0;
      mean_r    <= '0;
    end
    if (state_r == ST_WMEAN && div_done) begin
      mean_r <= (div_quo[CW-1:DW] != '0) ? '1 : div_quo[DW-1:0];
    end
    if (state_r == ST_OUT) begin
      out_samples_r <= samples_r;
      out_mean_r    <= mean_r;
      out_max_r     <= peak_sel;
      out_frames_r  <= frames_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_count    = out_samples_r;
  assign out_mean_us         = out_mean_r;
  assign out_max_us          = out_max_r;
  assign out_replaced_frames = out_frames_r;

  `SLSU_ASSERT(a_strobe_single, out_valid_r |=> !out_valid_r)
  `SLSU_ASSERT_NEVER(a_div_restart, div_start && div_busy)
  `SLSU_ASSERT(a_done_when_waiting,
               div_done |-> (state_r == ST_WSAMP || state_r == ST_WMEAN))

endmodule

// ===== sim/tb_sampled_latency_stats_unit.sv =====
// Self-checking testbench for sampled_latency_stats_unit: drives record, frame, read and
// clear requests and checks every result strobe against a built-in behavioural predictor.
// Depends on slsu_pkg and the unit's RTL only.
`timescale 1ns / 1ps
module tb_sampled_latency_stats_unit;

  // One request as presented on the in_ ports
  typedef struct {
    logic [1:0]                 kind;
    logic [slsu_pkg::IDX_W-1:0] metric;
    logic [slsu_pkg::DUR_W-1:0] dur;
  } stats_req_t;

  // One result as strobed on the out_ ports
  typedef struct {
    logic [slsu_pkg::CNT_W-1:0] samples;
    logic [slsu_pkg::DUR_W-1:0] mean;
    logic [slsu_pkg::DUR_W-1:0] peak;
    logic [slsu_pkg::CNT_W-1:0] frames;
  } stats_report_t;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 120;   // a little over one request's latency

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [1:0]                     in_req_type = slsu_pkg::REQ_READ;
  logic [slsu_pkg::IDX_W-1:0]     in_metric_index = '0;
  logic [slsu_pkg::DUR_W-1:0]     in_duration_us = '0;
  logic                           out_valid;
  logic [slsu_pkg::CNT_W-1:0]     out_sample_count;
  logic [slsu_pkg::DUR_W-1:0]     out_mean_us;
  logic [slsu_pkg::DUR_W-1:0]     out_max_us;
  logic [slsu_pkg::CNT_W-1:0]     out_replaced_frames;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [slsu_pkg::CFG_IDX_W-1:0] cfg_index = slsu_pkg::CFG_ENABLE;
  logic [slsu_pkg::EVERY_W-1:0]   cfg_wdata = '0;

  sampled_latency_stats_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_metric_index     (in_metric_index),
    .in_duration_us      (in_duration_us),
    .out_valid           (out_valid),
    .out_sample_count    (out_sample_count),
    .out_mean_us         (out_mean_us),
    .out_max_us          (out_max_us),
    .out_replaced_frames (out_replaced_frames),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the counters and both registers
  // ---------------------------------------------------------------------------
  logic [slsu_pkg::CNT_W-1:0]   attempts  [slsu_pkg::NUM_METRICS];
  logic [slsu_pkg::CNT_W-1:0]   kept_sum  [slsu_pkg::NUM_METRICS];
  logic [slsu_pkg::DUR_W-1:0]   kept_peak [slsu_pkg::NUM_METRICS];
  logic [slsu_pkg::CNT_W-1:0]   frame_tally;
  logic                         counting_on;
  logic [slsu_pkg::EVERY_W-1:0] keep_every;

  stats_req_t    request_backlog[$];   // requests waiting for the driver
  stats_report_t expected_reports[$];  // predicted results, oldest first
  stats_req_t    in_flight;            // request currently on the in_ ports
  int            sender_idle_pct = 0;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;

  function automatic void clear_stats();
    for (int i = 0; i < slsu_pkg::NUM_METRICS; i++) begin
      attempts[i]  = '0;
      kept_sum[i]  = '0;
      kept_peak[i] = '0;
    end
    frame_tally = '0;
  endfunction

  // Apply one accepted request to the predictor and return the result it must yield.
  function automatic stats_report_t apply_request(input stats_req_t rq);
    stats_report_t              rep;
    logic                       in_range;
    logic [slsu_pkg::CNT_W-1:0] n;
    logic [slsu_pkg::CNT_W-1:0] quotient;
    in_range = rq.metric < slsu_pkg::NUM_METRICS;
    case (rq.kind)
      slsu_pkg::REQ_RECORD: begin
        if (counting_on && in_range) begin
          n = attempts[rq.metric] + 1'b1;
          attempts[rq.metric] = n;
          // keep the duration only on every Nth attempt; a wrap to 0 counts as kept
          if (n % keep_every == 0) begin
            kept_sum[rq.metric] = kept_sum[rq.metric] + rq.dur;
            if (rq.dur > kept_peak[rq.metric]) kept_peak[rq.metric] = rq.dur;
          end
        end
      end
      slsu_pkg::REQ_FRAME: begin
        if (counting_on) frame_tally = frame_tally + 1'b1;
      end
      slsu_pkg::REQ_CLEAR: clear_stats();
      default: ;
    endcase
    rep.samples = '0;
    rep.mean    = '0;
    rep.peak    = '0;
    if (in_range) begin
      rep.samples = attempts[rq.metric] / keep_every;
      if (rep.samples != 0) begin
        quotient = kept_sum[rq.metric] / rep.samples;
        // saturate a mean that no longer fits in 32 bits
        rep.mean = (quotient[slsu_pkg::CNT_W-1:slsu_pkg::DUR_W] != '0) ?
                   {slsu_pkg::DUR_W{1'b1}} : quotient[slsu_pkg::DUR_W-1:0];
      end
      rep.peak = kept_peak[rq.metric];
    end
    rep.frames = frame_tally;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued requests on start, honour busy, predict on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      // a request on the ports with busy low was taken at this edge
      if (start) expected_reports.push_back(apply_request(in_flight));
      if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_flight = request_backlog.pop_front();
        start           <= 1'b1;
        in_req_type     <= in_flight.kind;
        in_metric_index <= in_flight.metric;
        in_duration_us  <= in_flight.dur;
      end else begin
        start <= 1'b0;
      end
    end
    // otherwise hold the request until busy drops
  end

  // ---------------------------------------------------------------------------
  // Monitor: each strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stats_report_t want;
    if (rst_n && out_valid) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: count=%0d mean=%0d max=%0d frames=%0d",
                   out_sample_count, out_mean_us, out_max_us, out_replaced_frames);
      end else begin
        want = expected_reports.pop_front();
        if (out_sample_count !== want.samples || out_mean_us !== want.mean ||
            out_max_us !== want.peak || out_replaced_frames !== want.frames) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: exp count=%0d mean=%0d max=%0d frames=%0d,",
                      " got count=%0d mean=%0d max=%0d frames=%0d"},
                     want.samples, want.mean, want.peak, want.frames,
                     out_sample_count, out_mean_us, out_max_us, out_replaced_frames);
        end
      end
    end
  end

  // Watchdog: any handshake restarts the count of quiet cycles
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(input logic [1:0] kind, input int metric,
                               input logic [slsu_pkg::DUR_W-1:0] dur);
    stats_req_t rq;
    rq.kind   = kind;
    rq.metric = metric[slsu_pkg::IDX_W-1:0];
    rq.dur    = dur;
    request_backlog.push_back(rq);
  endtask

  function automatic stats_req_t random_request();
    stats_req_t rq;
    int         pick;
    pick = $urandom_range(99);
    // mostly records, so that counters climb and samples get kept
    if (pick < 55)      rq.kind = slsu_pkg::REQ_RECORD;
    else if (pick < 70) rq.kind = slsu_pkg::REQ_FRAME;
    else if (pick < 97) rq.kind = slsu_pkg::REQ_READ;
    else                rq.kind = slsu_pkg::REQ_CLEAR;
    // now and then address a metric beyond the bank
    if ($urandom_range(9) == 0)
      rq.metric = slsu_pkg::IDX_W'($urandom_range(15, slsu_pkg::NUM_METRICS));
    else
      rq.metric = slsu_pkg::IDX_W'($urandom_range(slsu_pkg::NUM_METRICS - 1));
    case ($urandom_range(4))
      0:       rq.dur = '0;
      1:       rq.dur = '1;
      2:       rq.dur = $urandom_range(1000);
      3:       rq.dur = $urandom;
      default: rq.dur = $urandom >> $urandom_range(31);
    endcase
    return rq;
  endfunction

  // Wait on falling edges until nothing is pending, presented or outstanding.
  task automatic wait_idle();
    do @(negedge clk);
    while (request_backlog.size() != 0 || start || expected_reports.size() != 0);
  endtask

  // Write one register and mirror it into the predictor on the handshake.
  task automatic write_register(input logic [slsu_pkg::CFG_IDX_W-1:0] idx,
                                input logic [slsu_pkg::EVERY_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == slsu_pkg::CFG_ENABLE) counting_on = data[0];
    else keep_every = (data == '0) ? slsu_pkg::EVERY_W'(1) : data;
  endtask

  // Reprogram both registers while the unit is idle; return on a falling edge.
  task automatic configure(input logic en, input int every);
    logic [slsu_pkg::EVERY_W-1:0] word;
    wait_idle();
    word    = slsu_pkg::EVERY_W'($urandom);  // stray upper bits on the enable write
    word[0] = en;
    write_register(slsu_pkg::CFG_ENABLE, word);
    write_register(slsu_pkg::CFG_KEEP_RATE, every[slsu_pkg::EVERY_W-1:0]);
    @(negedge clk);
  endtask

  task automatic random_phase(input logic en, input int every, input int idle_pct,
                              input int count);
    configure(en, every);
    sender_idle_pct = idle_pct;
    repeat (count) request_backlog.push_back(random_request());
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_stats();
    counting_on = 1'b0;
    keep_every  = slsu_pkg::EVERY_W'(1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Disabled after reset: records and frames must change nothing
    queue_request(slsu_pkg::REQ_READ,   0,  '0);
    queue_request(slsu_pkg::REQ_RECORD, 0,  '1);
    queue_request(slsu_pkg::REQ_FRAME,  2,  '0);
    queue_request(slsu_pkg::REQ_READ,   15, '0);

    // Enabled, keep rate written as zero (taken as one); extremes and bad metrics
    configure(1'b1, 0);
    queue_request(slsu_pkg::REQ_RECORD, 0,  '0);
    queue_request(slsu_pkg::REQ_RECORD, 0,  '1);
    queue_request(slsu_pkg::REQ_RECORD, 8,  32'h8000_0001);
    queue_request(slsu_pkg::REQ_RECORD, 9,  32'd5);
    queue_request(slsu_pkg::REQ_RECORD, 15, '1);
    queue_request(slsu_pkg::REQ_FRAME,  0,  '0);
    queue_request(slsu_pkg::REQ_FRAME,  12, '0);
    queue_request(slsu_pkg::REQ_READ,   8,  '0);
    queue_request(slsu_pkg::REQ_READ,   15, '0);
    repeat (6) queue_request(slsu_pkg::REQ_RECORD, 3, '1);

    // Raise the keep rate so one sample carries six full durations: mean saturates
    configure(1'b1, 6);
    queue_request(slsu_pkg::REQ_READ, 3, '0);
    queue_request(slsu_pkg::REQ_READ, 0, '0);

    // Past the attempt count: no samples, mean zero; then clear and read back
    configure(1'b1, 7);
    queue_request(slsu_pkg::REQ_READ,  3, '0);
    queue_request(slsu_pkg::REQ_CLEAR, 3, '0);
    queue_request(slsu_pkg::REQ_READ,  3, '0);

    // Random phases across settings and sender idling
    random_phase(1'b1, 1,     0,  300);
    random_phase(1'b1, 3,     50, 300);
    random_phase(1'b0, 2,     26, 150);
    random_phase(1'b1, 0,     26, 250);
    random_phase(1'b1, 65535, 0,  200);
    random_phase(1'b1, $urandom_range(8, 1), 50, 300);
    random_phase(1'b1, 5,     0,  250);

    // Drain, then allow a latency's worth of cycles for any stray strobe
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
